FILE: rtl/core/cts_pkg.sv
`default_nettype none

package cts_pkg;

    localparam int TERM_COUNT_DEF      = 12;
    localparam int ANGLE_FRAC_BITS_DEF = 28;

    localparam int ANGLE_W = 32;
    localparam int COS_W   = 32;
    localparam int U_W     = 48;
    localparam int ACC_W   = 60;
    localparam int MAG_W   = 59;

    // Angle constants in Q28.
    localparam logic signed [31:0] TWO_PI_Q28   = 32'sd1686629713;
    localparam logic signed [31:0] PI_Q28       = 32'sd843314857;
    localparam logic signed [31:0] PI_3_Q28     = 32'sd281104952;
    localparam logic signed [31:0] TWO_PI_3_Q28 = 32'sd562209904;
    localparam logic signed [31:0] PI_2_Q28     = 32'sd421657428;

    localparam logic signed [COS_W-1:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [COS_W-1:0] HALF_Q30 = 32'sd536870912;

    // Coefficient magnitudes in Q48: d_k = round(d_{k-1} * 64 / ((2k)(2k-1))).
    localparam logic [63:0] COEF_D0  = 64'd1 << 48;
    localparam logic [63:0] COEF_D1  = (COEF_D0 * 64'd64 + 64'd1) / 64'd2;
    localparam logic [63:0] COEF_D2  = (COEF_D1 * 64'd64 + 64'd6) / 64'd12;
    localparam logic [63:0] COEF_D3  = (COEF_D2 * 64'd64 + 64'd15) / 64'd30;
    localparam logic [63:0] COEF_D4  = (COEF_D3 * 64'd64 + 64'd28) / 64'd56;
    localparam logic [63:0] COEF_D5  = (COEF_D4 * 64'd64 + 64'd45) / 64'd90;
    localparam logic [63:0] COEF_D6  = (COEF_D5 * 64'd64 + 64'd66) / 64'd132;
    localparam logic [63:0] COEF_D7  = (COEF_D6 * 64'd64 + 64'd91) / 64'd182;
    localparam logic [63:0] COEF_D8  = (COEF_D7 * 64'd64 + 64'd120) / 64'd240;
    localparam logic [63:0] COEF_D9  = (COEF_D8 * 64'd64 + 64'd153) / 64'd306;
    localparam logic [63:0] COEF_D10 = (COEF_D9 * 64'd64 + 64'd190) / 64'd380;
    localparam logic [63:0] COEF_D11 = (COEF_D10 * 64'd64 + 64'd231) / 64'd462;

    typedef enum logic [2:0] {
        SP_NONE,
        SP_ONE,
        SP_NEG_ONE,
        SP_HALF,
        SP_NEG_HALF,
        SP_ZERO
    } t_special;

    typedef struct packed {
        logic     valid;
        t_special special;
    } t_ctl;

    // Round a Q28 angle constant to the input format, half up.
    function automatic logic signed [31:0] scale_const(input logic signed [31:0] c28,
                                                        input int shift);
        logic signed [31:0] res;
        res = c28;
        if (shift > 0) begin
            res = (c28 + (32'sd1 <<< (shift - 1))) >>> shift;
        end
        return res;
    endfunction

    // Signed Q48 Horner coefficient k: (-1)^k * 64^k / (2k)!, rounded step by step.
    function automatic logic signed [ACC_W-1:0] coef(input int k);
        logic [63:0]             d;
        logic signed [ACC_W-1:0] res;
        unique case (k)
            0:       d = COEF_D0;
            1:       d = COEF_D1;
            2:       d = COEF_D2;
            3:       d = COEF_D3;
            4:       d = COEF_D4;
            5:       d = COEF_D5;
            6:       d = COEF_D6;
            7:       d = COEF_D7;
            8:       d = COEF_D8;
            9:       d = COEF_D9;
            10:      d = COEF_D10;
            default: d = COEF_D11;
        endcase
        res = ACC_W'(d);
        if (k[0]) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cts_front.sv
`default_nettype none

module cts_front #(
    parameter int TERM_COUNT      = cts_pkg::TERM_COUNT_DEF,
    parameter int ANGLE_FRAC_BITS = cts_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [cts_pkg::ANGLE_W-1:0]  i_angle,
    output cts_pkg::t_ctl                            o_ctl,
    output logic        [cts_pkg::U_W-1:0]           o_u,
    output logic signed [cts_pkg::ACC_W-1:0]         o_acc
);

    localparam int SHIFT = 28 - ANGLE_FRAC_BITS;
    localparam int Z_W   = cts_pkg::ANGLE_W + SHIFT;

    localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(cts_pkg::TWO_PI_Q28);
    localparam logic signed [Z_W-1:0] Z_MIN = -Z_MAX;

    localparam logic signed [31:0] A_PI     = cts_pkg::scale_const(cts_pkg::PI_Q28, SHIFT);
    localparam logic signed [31:0] A_PI_3   = cts_pkg::scale_const(cts_pkg::PI_3_Q28, SHIFT);
    localparam logic signed [31:0] A_2PI_3  = cts_pkg::scale_const(cts_pkg::TWO_PI_3_Q28, SHIFT);
    localparam logic signed [31:0] A_PI_2   = cts_pkg::scale_const(cts_pkg::PI_2_Q28, SHIFT);

    localparam logic signed [cts_pkg::ACC_W-1:0] ACC_INIT = cts_pkg::coef(TERM_COUNT - 1);

    localparam logic [61:0]           ZSQ_MAX = 62'(cts_pkg::TWO_PI_Q28) * 62'(cts_pkg::TWO_PI_Q28);
    localparam logic [cts_pkg::U_W-1:0] U_MAX = cts_pkg::U_W'((ZSQ_MAX + 62'd8192) >> 14);

    // stage 1: exact-angle match and clamp
    cts_pkg::t_ctl      r_ctl1, n_ctl1;
    logic signed [31:0] r_z1, n_z1;
    logic signed [Z_W-1:0] z_wide;

    // stage 2: magnitude
    cts_pkg::t_ctl r_ctl2;
    logic [30:0]   r_m2, n_m2;

    // stage 3: square
    cts_pkg::t_ctl r_ctl3;
    logic [61:0]   r_sq3, n_sq3;

    // stage 4: u = z^2/64 in Q48
    cts_pkg::t_ctl            r_ctl4;
    logic [cts_pkg::U_W-1:0]  r_u4, n_u4;
    logic [61:0]              sq_rnd;

    assign z_wide = Z_W'(i_angle) <<< SHIFT;

    always_comb begin
        n_ctl1.valid = i_valid;
        priority if (i_angle == '0) begin
            n_ctl1.special = cts_pkg::SP_ONE;
        end else if (i_angle == A_PI) begin
            n_ctl1.special = cts_pkg::SP_NEG_ONE;
        end else if (i_angle == A_PI_3) begin
            n_ctl1.special = cts_pkg::SP_HALF;
        end else if (i_angle == A_2PI_3) begin
            n_ctl1.special = cts_pkg::SP_NEG_HALF;
        end else if (i_angle == A_PI_2) begin
            n_ctl1.special = cts_pkg::SP_ZERO;
        end else begin
            n_ctl1.special = cts_pkg::SP_NONE;
        end

        priority if (z_wide > Z_MAX) begin
            n_z1 = cts_pkg::TWO_PI_Q28;
        end else if (z_wide < Z_MIN) begin
            n_z1 = -cts_pkg::TWO_PI_Q28;
        end else begin
            n_z1 = 32'(z_wide);
        end
    end

    assign n_m2   = r_z1[31] ? 31'(-r_z1) : 31'(r_z1);
    assign n_sq3  = r_m2 * r_m2;
    assign sq_rnd = (r_sq3 + 62'd8192) >> 14;
    assign n_u4   = sq_rnd[cts_pkg::U_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1  <= n_z1;
            r_m2  <= n_m2;
            r_sq3 <= n_sq3;
            r_u4  <= n_u4;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_u   = r_u4;
    assign o_acc = ACC_INIT;

`ifndef ASSERT_OFF
    a_zero_angle_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_angle == '0) |=> (r_ctl1.special == cts_pkg::SP_ONE))
        else $error("zero angle not flagged as exact one");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl1.valid |-> (r_z1 <= cts_pkg::TWO_PI_Q28 && r_z1 >= -cts_pkg::TWO_PI_Q28))
        else $error("clamped angle out of range");

    a_u_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl4.valid |-> (r_u4 <= U_MAX))
        else $error("u exceeds bound of clamped angle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cts_horner_step.sv
`default_nettype none

module cts_horner_step #(
    parameter int K_IDX = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire cts_pkg::t_ctl                       i_ctl,
    input  wire logic        [cts_pkg::U_W-1:0]      i_u,
    input  wire logic signed [cts_pkg::ACC_W-1:0]    i_acc,
    output cts_pkg::t_ctl                            o_ctl,
    output logic        [cts_pkg::U_W-1:0]           o_u,
    output logic signed [cts_pkg::ACC_W-1:0]         o_acc
);

    localparam logic signed [cts_pkg::ACC_W-1:0] COEF = cts_pkg::coef(K_IDX);

    // stage 1: sign and magnitude
    cts_pkg::t_ctl                r_ctl1;
    logic [cts_pkg::U_W-1:0]      r_u1;
    logic                         r_neg1;
    logic [cts_pkg::MAG_W-1:0]    r_mag1, n_mag1;

    // stage 2: four partial products
    cts_pkg::t_ctl           r_ctl2;
    logic [cts_pkg::U_W-1:0] r_u2;
    logic                    r_neg2;
    logic [53:0]             r_pp00, r_pp10, n_pp00, n_pp10;
    logic [52:0]             r_pp01, r_pp11, n_pp01, n_pp11;

    // stage 3: pairwise sums
    cts_pkg::t_ctl           r_ctl3;
    logic [cts_pkg::U_W-1:0] r_u3;
    logic                    r_neg3;
    logic [82:0]             r_lo3, r_hi3, n_lo3, n_hi3;

    // stage 4: full product rounded at 2^48
    cts_pkg::t_ctl             r_ctl4;
    logic [cts_pkg::U_W-1:0]   r_u4;
    logic                      r_neg4;
    logic [cts_pkg::MAG_W-1:0] r_r4, n_r4;
    logic [107:0]              tot;

    // stage 5: add coefficient
    cts_pkg::t_ctl                       r_ctl5;
    logic [cts_pkg::U_W-1:0]             r_u5;
    logic signed [cts_pkg::ACC_W-1:0]    r_acc5, n_acc5;
    logic signed [cts_pkg::ACC_W-1:0]    term_s;

    assign n_mag1 = i_acc[cts_pkg::ACC_W-1] ? cts_pkg::MAG_W'(-i_acc)
                                             : cts_pkg::MAG_W'(i_acc);

    assign n_pp00 = r_u1[23:0]  * r_mag1[29:0];
    assign n_pp01 = r_u1[23:0]  * r_mag1[58:30];
    assign n_pp10 = r_u1[47:24] * r_mag1[29:0];
    assign n_pp11 = r_u1[47:24] * r_mag1[58:30];

    assign n_lo3 = 83'(r_pp00) + (83'(r_pp01) << 30);
    assign n_hi3 = 83'(r_pp10) + (83'(r_pp11) << 30);

    assign tot  = 108'(r_lo3) + (108'(r_hi3) << 24) + (108'd1 << 47);
    assign n_r4 = tot[106:48];

    assign term_s = $signed({1'b0, r_r4});
    assign n_acc5 = r_neg4 ? (COEF - term_s) : (COEF + term_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1   <= i_u;
            r_neg1 <= i_acc[cts_pkg::ACC_W-1];
            r_mag1 <= n_mag1;
            r_u2   <= r_u1;
            r_neg2 <= r_neg1;
            r_pp00 <= n_pp00;
            r_pp01 <= n_pp01;
            r_pp10 <= n_pp10;
            r_pp11 <= n_pp11;
            r_u3   <= r_u2;
            r_neg3 <= r_neg2;
            r_lo3  <= n_lo3;
            r_hi3  <= n_hi3;
            r_u4   <= r_u3;
            r_neg4 <= r_neg3;
            r_r4   <= n_r4;
            r_u5   <= r_u4;
            r_acc5 <= n_acc5;
        end
    end

    assign o_ctl = r_ctl5;
    assign o_u   = r_u5;
    assign o_acc = r_acc5;

endmodule

`default_nettype wire

FILE: rtl/core/cts_back.sv
`default_nettype none

module cts_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire cts_pkg::t_ctl                       i_ctl,
    input  wire logic signed [cts_pkg::ACC_W-1:0]    i_acc,
    output logic                                     o_valid,
    output logic signed [cts_pkg::COS_W-1:0]         o_cosine
);

    localparam logic [30:0] Q_ONE = 31'(cts_pkg::ONE_Q30);

    // stage 1: sign and magnitude
    cts_pkg::t_ctl             r_ctl1;
    logic                      r_neg1;
    logic [cts_pkg::MAG_W-1:0] r_mag1, n_mag1;

    // stage 2: round to Q30 and saturate
    cts_pkg::t_ctl r_ctl2;
    logic          r_neg2;
    logic [30:0]   r_q2, n_q2;
    logic [59:0]   rnd;
    logic [41:0]   q_full;

    // stage 3: sign and exact values, output register
    logic                             r_valid3;
    logic signed [cts_pkg::COS_W-1:0] r_cos3, n_cos3;

    assign n_mag1 = i_acc[cts_pkg::ACC_W-1] ? cts_pkg::MAG_W'(-i_acc)
                                             : cts_pkg::MAG_W'(i_acc);

    assign rnd    = 60'(r_mag1) + 60'd131072;
    assign q_full = rnd[59:18];
    assign n_q2   = (q_full > 42'(Q_ONE)) ? Q_ONE : q_full[30:0];

    always_comb begin
        unique case (r_ctl2.special)
            cts_pkg::SP_ONE:      n_cos3 = cts_pkg::ONE_Q30;
            cts_pkg::SP_NEG_ONE:  n_cos3 = -cts_pkg::ONE_Q30;
            cts_pkg::SP_HALF:     n_cos3 = cts_pkg::HALF_Q30;
            cts_pkg::SP_NEG_HALF: n_cos3 = -cts_pkg::HALF_Q30;
            cts_pkg::SP_ZERO:     n_cos3 = '0;
            cts_pkg::SP_NONE:     n_cos3 = r_neg2 ? -$signed(32'(r_q2)) : $signed(32'(r_q2));
            default:              n_cos3 = r_neg2 ? -$signed(32'(r_q2)) : $signed(32'(r_q2));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1   <= '0;
            r_ctl2   <= '0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_ctl1   <= i_ctl;
            r_ctl2   <= r_ctl1;
            r_valid3 <= r_ctl2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_acc[cts_pkg::ACC_W-1];
            r_mag1 <= n_mag1;
            r_neg2 <= r_neg1;
            r_q2   <= n_q2;
            r_cos3 <= n_cos3;
        end
    end

    assign o_valid  = r_valid3;
    assign o_cosine = r_cos3;

`ifndef ASSERT_OFF
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl2.valid |-> (r_q2 <= Q_ONE))
        else $error("rounded magnitude not saturated");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cosine <= cts_pkg::ONE_Q30 && o_cosine >= -cts_pkg::ONE_Q30))
        else $error("cosine outside plus or minus one");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cosine_taylor_series.sv
// Cosine by a Maclaurin series of TERM_COUNT even terms, Horner's rule in z^2/64.
// Pipeline: four front stages, five per Horner step (TERM_COUNT-1 steps, each a
// 48x59 multiply split in four partial products), three back.
// Throughput: one transfer per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
`default_nettype none

module cosine_taylor_series #(
    parameter int TERM_COUNT      = cts_pkg::TERM_COUNT_DEF,
    parameter int ANGLE_FRAC_BITS = cts_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [cts_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [cts_pkg::COS_W-1:0]         o_cosine
);

    logic en;

    cts_pkg::t_ctl                    ctl_c [TERM_COUNT];
    logic [cts_pkg::U_W-1:0]          u_c   [TERM_COUNT];
    logic signed [cts_pkg::ACC_W-1:0] acc_c [TERM_COUNT];

    // advance unless a finished result is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    cts_front #(
        .TERM_COUNT      (TERM_COUNT),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .o_ctl   (ctl_c[0]),
        .o_u     (u_c[0]),
        .o_acc   (acc_c[0])
    );

    for (genvar s = 0; s < TERM_COUNT - 1; s++) begin : g_step
        cts_horner_step #(
            .K_IDX (TERM_COUNT - 2 - s)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_c[s]),
            .i_u     (u_c[s]),
            .i_acc   (acc_c[s]),
            .o_ctl   (ctl_c[s+1]),
            .o_u     (u_c[s+1]),
            .o_acc   (acc_c[s+1])
        );
    end

    cts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (ctl_c[TERM_COUNT-1]),
        .i_acc    (acc_c[TERM_COUNT-1]),
        .o_valid  (o_valid),
        .o_cosine (o_cosine)
    );

endmodule

`default_nettype wire

FILE: test/tb_cosine_taylor_series.sv
`default_nettype none

module tb_cosine_taylor_series;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS        = 12;
    localparam int PIPE_DEPTH   = 5 * TERMS + 2;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_PRINTED  = 40;
    localparam int RANDOM_ITEMS = 950;

    localparam logic signed [31:0] ANG_TWO_PI   = 32'sd1686629713;
    localparam logic signed [31:0] ANG_PI       = 32'sd843314857;
    localparam logic signed [31:0] ANG_PI_3     = 32'sd281104952;
    localparam logic signed [31:0] ANG_TWO_PI_3 = 32'sd562209904;
    localparam logic signed [31:0] ANG_PI_2     = 32'sd421657428;
    localparam logic signed [31:0] COS_ONE      = 32'sd1073741824;
    localparam logic signed [31:0] COS_HALF     = 32'sd536870912;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] cosine;
    } t_cos_pair;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_angle;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_cosine;

    t_cos_pair cos_queue[$];
    longint    horner_coef[TERMS];

    int  error_count    = 0;
    int  angles_sent    = 0;
    int  directed_sent  = 0;
    int  beyond_sent    = 0;
    int  cosines_seen   = 0;
    int  out_hold_left  = 0;
    int  quiet_cycles   = 0;
    bit  in_gaps_on     = 1'b1;
    bit  out_gaps_on    = 1'b1;

    cosine_taylor_series u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_angle  (i_angle),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cosine (o_cosine)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Maclaurin series in u = z^2/64 by Horner's rule in Q48, result in Q30; special angles exact.
    function automatic logic signed [31:0] cos_expected(input logic signed [31:0] angle);
        longint             z;
        longint             acc;
        longint             term;
        longint unsigned    mag;
        longint unsigned    u;
        longint unsigned    q;
        logic [127:0]       prod;
        logic signed [31:0] res;
        int                 k;
        if (angle == 0) begin
            res = COS_ONE;
        end else if (angle == ANG_PI) begin
            res = -COS_ONE;
        end else if (angle == ANG_PI_3) begin
            res = COS_HALF;
        end else if (angle == ANG_TWO_PI_3) begin
            res = -COS_HALF;
        end else if (angle == ANG_PI_2) begin
            res = '0;
        end else begin
            z = angle;
            if (z > longint'(ANG_TWO_PI)) begin
                z = ANG_TWO_PI;
            end
            if (z < -longint'(ANG_TWO_PI)) begin
                z = -longint'(ANG_TWO_PI);
            end
            mag = (z < 0) ? -z : z;
            u = (mag * mag + 64'd8192) >> 14;
            acc = horner_coef[TERMS-1];
            for (k = TERMS - 2; k >= 0; k--) begin
                mag  = (acc < 0) ? -acc : acc;
                prod = {64'd0, u} * {64'd0, mag};
                prod = (prod + (128'd1 << 47)) >> 48;
                term = longint'(prod[63:0]);
                acc  = horner_coef[k] + ((acc < 0) ? -term : term);
            end
            mag = (acc < 0) ? -acc : acc;
            q = (mag + 64'd131072) >> 18;
            if (q > 64'd1073741824) begin
                q = 64'd1073741824;
            end
            res = (acc < 0) ? -32'(q) : 32'(q);
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // Present one angle after a random gap when input gaps are on, and hold it until the transfer.
    task automatic send_angle(input logic signed [31:0] angle);
        int gap;
        t_cos_pair pair;
        gap = in_gaps_on ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_angle = angle;
        do @(posedge i_clk); while (o_stall);
        pair.angle  = angle;
        pair.cosine = cos_expected(angle);
        cos_queue.push_back(pair);
        angles_sent++;
        if (angle > ANG_TWO_PI || angle < -ANG_TWO_PI) begin
            beyond_sent++;
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Output side: after each result, hold stall for a random count when output gaps are on.
    always @(negedge i_clk) begin
        if (out_hold_left > 0) begin
            i_stall = 1'b1;
            out_hold_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_cos_pair pair;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cos_queue.size() == 0) begin
                report_error($sformatf("cosine %0d with no angle pending", o_cosine));
            end else begin
                pair = cos_queue.pop_front();
                if (o_cosine !== pair.cosine) begin
                    report_error($sformatf("angle %0d: cosine %0d, want %0d",
                                           pair.angle, o_cosine, pair.cosine));
                end
            end
            cosines_seen++;
            out_hold_left = out_gaps_on ? $urandom_range(0, 8) : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d results pending",
                         quiet_cycles, cos_queue.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic test_exact_angles();
        logic signed [31:0] angles[$];
        angles = '{32'sd0, ANG_PI, ANG_PI_3, ANG_TWO_PI_3, ANG_PI_2,
                   ANG_PI - 1, ANG_PI + 1, -ANG_PI, -ANG_PI_2, -ANG_PI_3, -ANG_TWO_PI_3};
        foreach (angles[i]) begin
            send_angle(angles[i]);
        end
        directed_sent += angles.size();
    endtask

    task automatic test_range_edges();
        logic signed [31:0] angles[$];
        angles = '{ANG_TWO_PI, -ANG_TWO_PI, ANG_TWO_PI - 1, ANG_TWO_PI + 1, -ANG_TWO_PI - 1,
                   32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1};
        foreach (angles[i]) begin
            send_angle(angles[i]);
        end
        directed_sent += angles.size();
    endtask

    task automatic test_random_angles(input int count, input bit in_gaps, input bit out_gaps);
        logic signed [31:0] specials[5];
        logic signed [31:0] angle;
        int                 pick;
        specials    = '{32'sd0, ANG_PI, ANG_PI_3, ANG_TWO_PI_3, ANG_PI_2};
        in_gaps_on  = in_gaps;
        out_gaps_on = out_gaps;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                angle = 32'($urandom_range(32'd3373259426, 0)) - ANG_TWO_PI;
            end else if (pick == 6) begin
                angle = specials[$urandom_range(0, 4)] + $signed($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 3) == 0) begin
                    angle = -angle;
                end
            end else if (pick == 7) begin
                angle = $signed($urandom >> $urandom_range(1, 31));
                if ($urandom_range(0, 1)) begin
                    angle = -angle;
                end
            end else if (pick == 8) begin
                angle = ANG_TWO_PI - $signed($urandom_range(0, 1000));
                if ($urandom_range(0, 1)) begin
                    angle = -angle;
                end
            end else begin
                angle = $urandom;
            end
            send_angle(angle);
        end
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    initial begin
        logic [63:0] d;
        logic [63:0] q;
        int          k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_angle = '0;
        i_stall = 1'b0;
        d = 64'd1 << 48;
        horner_coef[0] = longint'(d);
        for (k = 1; k < TERMS; k++) begin
            q = 64'(2 * k) * 64'(2 * k - 1);
            d = (d * 64'd64 + (q >> 1)) / q;
            horner_coef[k] = k[0] ? -longint'(d) : longint'(d);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_exact_angles();
        test_range_edges();
        test_random_angles(RANDOM_ITEMS / 4, 1'b1, 1'b1);
        test_random_angles(RANDOM_ITEMS / 4, 1'b0, 1'b1);
        test_random_angles(RANDOM_ITEMS / 4, 1'b1, 1'b0);
        test_random_angles(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4), 1'b0, 1'b0);
        drop_valid();

        while (cos_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);

        $display("covered %0d angles (%0d directed, %0d beyond two pi), %0d cosines checked",
                 angles_sent, directed_sent, beyond_sent, cosines_seen);
        $display("exact constants, range clamp and saturation exercised; %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: cosine_taylor_series.f
rtl/core/cts_pkg.sv
rtl/core/cts_front.sv
rtl/core/cts_horner_step.sv
rtl/core/cts_back.sv
rtl/core/cosine_taylor_series.sv
test/tb_cosine_taylor_series.sv
